[sv/btff_pkg.sv]
// Package: shared types and constants for the boundary-tag allocator.
`default_nettype none
package btff_pkg;
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_NOINIT  = 2'd3;

  localparam logic CFG_CHUNK = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam int REQ_W  = 17;
  localparam int ADDR_W = 16;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] req;
    logic [15:0] fa;
  } btff_cmd_t;
endpackage
`default_nettype wire

[sv/btff_if.sv]
// Interfaces: request and result channels.
`default_nettype none
interface btff_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [16:0] request_size;
  logic [15:0] free_address;
  modport source (output valid, mode, request_size, free_address, input ready);
  modport sink (input valid, mode, request_size, free_address, output ready);
endinterface

interface btff_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_address;
  logic [1:0]  status;
  modport source (output valid, payload_address, status, input ready);
  modport sink (input valid, payload_address, status, output ready);
endinterface
`default_nettype wire

[sv/btff_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module btff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[sv/btff_front.sv]
// Front end: accepts requests and queues them for the executor.
`default_nettype none
module btff_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  btff_req_if.sink                   req,
  output logic                       cmd_valid,
  output btff_pkg::btff_cmd_t        cmd,
  input  wire logic                  cmd_take
);
  import btff_pkg::*;

  // Two-entry queue
  btff_cmd_t q [2];
  logic      wptr, rptr;
  logic [1:0] count;

  assign req.ready = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q[wptr] <= '{mode: req.mode, req: req.request_size, fa: req.free_address};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (req.valid && req.ready) wptr <= ~wptr;
      if (cmd_take && cmd_valid) rptr <= ~rptr;
      count <= count + {1'b0, req.valid && req.ready} - {1'b0, cmd_take && cmd_valid};
    end
  end
endmodule
`default_nettype wire

[sv/btff_back.sv]
// Back end: sequencer that walks and updates the heap words.
`default_nettype none
module btff_back #(
  parameter int HEAP_WORDS = 16384
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  wire btff_pkg::btff_cmd_t cmd,
  output logic                     cmd_take,
  input  wire logic [16:0]         chunk_bytes,
  input  wire logic [16:0]         heap_limit_bytes,
  btff_rsp_if.source               rsp,
  output logic                     busy
);
  import btff_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);
  localparam logic [31:0] TAG_A = 32'h1;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_INIT  = 16'h0002,
    S_GROW  = 16'h0004,
    S_MRD0  = 16'h0008,
    S_MRD1  = 16'h0010,
    S_MRD2  = 16'h0020,
    S_MRD3  = 16'h0040,
    S_MWR   = 16'h0080,
    S_WALK  = 16'h0100,
    S_WCHK  = 16'h0200,
    S_TAKE  = 16'h0400,
    S_TWR   = 16'h0800,
    S_FREE0 = 16'h1000,
    S_FREE1 = 16'h2000,
    S_RSP   = 16'h4000,
    S_WAIT  = 16'h8000
  } state_t;

  state_t state;
  logic [1:0]  mode;
  logic [17:0] brk;       // break offset
  logic        ready_h;
  logic [17:0] bp;        // block pointer
  logic [17:0] asize;
  logic [17:0] size, psize, nsize;
  logic        palloc;
  logic        nalloc;
  logic [2:0]  step;
  logic [1:0]  st;
  logic [15:0] paddr;
  logic        in_init;

  // RAM port
  logic          we;
  logic [17:0]   byte_a;
  logic [31:0]   wdata, rdata;
  logic [AW-1:0] waddr;
  logic          inrange;

  assign inrange = ({3'b0, byte_a} >> 2) < 21'(HEAP_WORDS);
  assign waddr   = AW'(byte_a >> 2);

  btff_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_ram (
    .clk(clk), .we(we && inrange), .addr(waddr), .wdata(wdata), .rdata(rdata)
  );

  // Read-data view: out-of-range reads are zero
  logic        rd_oor;
  logic [31:0] rword;
  always_ff @(posedge clk) rd_oor <= !inrange;
  assign rword = rd_oor ? 32'h0 : rdata;

  // Effective limit
  logic [17:0] lim;
  always_comb begin
    lim = {1'b0, heap_limit_bytes};
    if (lim > 18'(HEAP_WORDS) * 18'd4 && HEAP_WORDS < 65536) lim = 18'(HEAP_WORDS * 4);
    if (lim > 18'd65536) lim = 18'd65536;
  end

  // Grow size: round bytes down to words, up to even words
  logic [16:0] ext_req;
  logic [17:0] gsize;
  assign ext_req = in_init ? chunk_bytes
                 : ((asize > {1'b0, chunk_bytes}) ? 17'(asize) : chunk_bytes);
  assign gsize = {((ext_req[16:2] + 15'd1) & ~15'd1) == 15'd0 && ext_req[16:2] != 15'd0
                   ? 1'b1 : 1'b0, ((ext_req[16:2] + 15'd1) & ~15'd1), 2'b00} ;

  logic [17:0] req_round;
  assign req_round = ({1'b0, cmd.req} + 18'd15) & ~18'd7;

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign busy = (state != S_IDLE) || cmd_valid;
  assign rsp.valid = (state == S_WAIT);
  assign rsp.payload_address = paddr;
  assign rsp.status = st;

  logic [17:0] csize;
  assign csize = rword[17:0] & ~18'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      brk <= '0;
      ready_h <= 1'b0;
      we <= 1'b0;
      st <= ST_OK;
      paddr <= '0;
    end else begin
      we <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          mode <= cmd.mode;
          st <= ST_OK;
          paddr <= '0;
          step <= '0;
          in_init <= 1'b0;
          asize <= (cmd.req <= 17'd8) ? 18'd16 : req_round;
          if (cmd.mode == MODE_INIT) begin
            ready_h <= 1'b0;
            brk <= '0;
            in_init <= 1'b1;
            if (lim < 18'd16) begin
              st <= ST_NOMEM; state <= S_RSP;
            end else state <= S_INIT;
          end else if (cmd.mode == MODE_NONE) state <= S_RSP;
          else if (!ready_h) begin
            st <= ST_NOINIT; state <= S_RSP;
          end else if (cmd.mode == MODE_ALLOC) begin
            if (cmd.req == '0) begin
              st <= ST_ZERO; state <= S_RSP;
            end else begin
              bp <= 18'd8; byte_a <= 18'd4; state <= S_WALK;
            end
          end else begin
            if (cmd.fa[2:0] == 3'd0 && cmd.fa >= 16'd16 && {2'b0, cmd.fa} < brk) begin
              bp <= {2'b0, cmd.fa}; byte_a <= {2'b0, cmd.fa} - 18'd4;
              state <= S_FREE0;
            end else state <= S_RSP;
          end
        end
        // Prologue and epilogue words
        S_INIT: begin
          we <= 1'b1;
          byte_a <= {14'd0, step[1:0], 2'b00};
          unique case (step[1:0])
            2'd0: wdata <= 32'h0;
            2'd1, 2'd2: wdata <= 32'h8 | TAG_A;
            default: wdata <= TAG_A;
          endcase
          if (step[1:0] == 2'd3) begin
            brk <= 18'd16; step <= '0; state <= S_GROW;
          end else step <= step + 3'd1;
        end
        // Extend heap, write new free block and epilogue
        S_GROW: begin
          if (step == 3'd0) begin
            if (gsize == '0 || brk + gsize > lim) begin
              st <= ST_NOMEM; state <= S_RSP;
            end else begin
              bp <= brk; size <= gsize; step <= 3'd1;
            end
          end else begin
            we <= 1'b1;
            unique case (step)
              3'd1: begin
                byte_a <= bp - 18'd4; wdata <= 32'(size); step <= step + 3'd1;
              end
              3'd2: begin
                byte_a <= bp + size - 18'd8; wdata <= 32'(size); step <= step + 3'd1;
              end
              default: begin
                byte_a <= bp + size - 18'd4; wdata <= TAG_A;
                brk <= bp + size; step <= '0; state <= S_MRD0;
              end
            endcase
          end
        end
        // Merge: read own header, prev footer, next header
        S_MRD0: begin byte_a <= bp - 18'd4; state <= S_MRD1; end
        S_MRD1: begin byte_a <= bp - 18'd8; state <= S_MRD2; end
        S_MRD2: begin
          size <= csize; byte_a <= bp + csize - 18'd4; state <= S_MRD3;
        end
        S_MRD3: begin
          psize <= csize; palloc <= rword[0]; state <= S_MWR; step <= '0;
        end
        S_MWR: begin
          if (step == 3'd0) begin
            nsize <= csize;
            nalloc <= rword[0];
            if (palloc && rword[0]) state <= S_TAKE;
            else step <= 3'd1;
          end else begin
            we <= 1'b1;
            step <= step + 3'd1;
            if (palloc) begin
              if (step == 3'd1) begin
                byte_a <= bp - 18'd4; wdata <= 32'(size + nsize);
              end else begin
                byte_a <= bp + size + nsize - 18'd8; wdata <= 32'(size + nsize);
                state <= S_TAKE;
              end
            end else if (nalloc) begin
              if (step == 3'd1) begin
                byte_a <= bp + size - 18'd8; wdata <= 32'(size + psize);
              end else begin
                byte_a <= bp - psize - 18'd4; wdata <= 32'(size + psize);
                bp <= bp - psize; state <= S_TAKE;
              end
            end else begin
              if (step == 3'd1) begin
                byte_a <= bp - psize - 18'd4; wdata <= 32'(size + psize + nsize);
              end else begin
                byte_a <= bp + size + nsize - 18'd8;
                wdata <= 32'(size + psize + nsize);
                bp <= bp - psize; state <= S_TAKE;
              end
            end
          end
        end
        // First-fit walk, one header read per block
        S_WALK: state <= S_WCHK;
        S_WCHK: begin
          if (bp >= brk || csize == '0) begin
            step <= '0; state <= S_GROW;
          end else if (!rword[0] && asize <= csize) state <= S_TAKE;
          else begin
            bp <= bp + csize; byte_a <= bp + csize - 18'd4; state <= S_WALK;
          end
        end
        // Take: on allocate, re-read header then write tags; otherwise finish the free or initialize
        S_TAKE: begin
          paddr <= '0;
          if (mode != MODE_ALLOC) begin
            if (in_init) ready_h <= 1'b1;
            state <= S_RSP;
          end else begin
            byte_a <= bp - 18'd4; step <= '0; state <= S_TWR;
          end
        end
        S_TWR: begin
          if (step == 3'd0) begin
            step <= 3'd1;
          end else if (step == 3'd1) begin
            size <= csize; step <= 3'd2;
          end else begin
            we <= 1'b1;
            step <= step + 3'd1;
            if (size - asize >= 18'd8 && size >= asize) begin
              unique case (step)
                3'd2: begin byte_a <= bp - 18'd4; wdata <= 32'(asize) | TAG_A; end
                3'd3: begin byte_a <= bp + asize - 18'd8; wdata <= 32'(asize) | TAG_A; end
                3'd4: begin byte_a <= bp + asize - 18'd4; wdata <= 32'(size - asize); end
                default: begin
                  byte_a <= bp + size - 18'd8; wdata <= 32'(size - asize);
                  paddr <= bp[15:0]; state <= S_RSP;
                end
              endcase
            end else begin
              if (step == 3'd2) begin
                byte_a <= bp - 18'd4; wdata <= 32'(size) | TAG_A;
              end else begin
                byte_a <= bp + size - 18'd8; wdata <= 32'(size) | TAG_A;
                paddr <= bp[15:0]; state <= S_RSP;
              end
            end
          end
        end
        // Free: read header, clear both tags, then merge
        S_FREE0: begin
          if (step == 3'd0) step <= 3'd1;
          else if (step == 3'd1) begin
            size <= csize; step <= 3'd2;
          end else if (step == 3'd2) begin
            we <= 1'b1; byte_a <= bp - 18'd4; wdata <= 32'(size); step <= 3'd3;
          end else begin
            we <= 1'b1; byte_a <= bp + size - 18'd8; wdata <= 32'(size);
            state <= S_FREE1;
          end
        end
        S_FREE1: state <= S_MRD0;
        S_RSP: state <= S_WAIT;
        S_WAIT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_GROW && step == 3'd0 && (gsize == '0 || brk + gsize > lim))
        paddr <= '0;
    end
  end
endmodule
`default_nettype wire

[sv/boundary_tag_first_fit_allocator_core.sv]
// Top level: boundary-tag first-fit heap allocator.
// One request in flight in the executor; a two-entry queue buffers the next ones.
// Reset (rst, synchronous) clears the break, ready flag and queues; heap
// words are left undefined until initialize writes them.
`default_nettype none
module boundary_tag_first_fit_allocator_core #(
  parameter int HEAP_WORDS = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  btff_req_if.sink         req,
  btff_rsp_if.source       rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);
  import btff_pkg::*;

  logic [16:0] chunk_bytes, heap_limit_bytes;
  logic        cmd_valid, cmd_take, busy;
  btff_cmd_t   cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= 17'd4096;
      heap_limit_bytes <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNK: chunk_bytes <= cfg_data;
        default:   heap_limit_bytes <= cfg_data;
      endcase
    end
  end

  btff_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  btff_back #(.HEAP_WORDS(HEAP_WORDS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .chunk_bytes(chunk_bytes), .heap_limit_bytes(heap_limit_bytes),
    .rsp(rsp), .busy(busy)
  );

`ifndef ASSERT_OFF
  // Non-ok results carry a null address
  a_null: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.payload_address == 16'd0)
    else $error("non-ok result with address");
  // Allocated payloads are 8-byte aligned
  a_align: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.payload_address[2:0] == 3'd0)
    else $error("misaligned payload");
  // A result implies the executor is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> busy)
    else $error("result while idle");
`endif
endmodule
`default_nettype wire
